// ===== sv/rva_pkg.sv =====
`default_nettype none
package rva_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TRIG_FRAC    = 30;
	localparam int MAT_FRAC     = 26;
	localparam int ATAN_LEN     = 24;

	localparam int AXIS_W  = 18;
	localparam int ANGLE_W = 20;
	localparam int VEC_W   = 32;

	// angle reduction: scaled angle, binary modulo steps, folding
	localparam int ANG_SHIFT = TRIG_FRAC - FRAC_BITS;
	localparam int ZW        = (52 - FRAC_BITS > 36) ? 52 - FRAC_BITS : 36;
	localparam int RED_STEPS = (17 - FRAC_BITS > 1) ? 17 - FRAC_BITS : 1;

	// CORDIC datapath
	localparam int CZ  = 35;
	localparam int XW  = 34;
	localparam int CFW = 35;

	// matrix build
	localparam int AAW    = 37 - FRAC_BITS;
	localparam int QW0    = 67 - 2 * FRAC_BITS;
	localparam int QW1    = 50 - FRAC_BITS;
	localparam int QWM    = (QW0 > QW1) ? QW0 : QW1;
	localparam int QW     = ((QWM > XW) ? QWM : XW) + 2;
	localparam int MW     = QW + 2;
	localparam int COEF_W = 31;
	localparam int PW     = COEF_W + VEC_W;
	localparam int SW     = PW + 2;
	localparam int RW     = SW - MAT_FRAC;

	localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
	localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
	localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
	localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;

	typedef struct packed {
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
		logic signed [VEC_W-1:0]  vx;
		logic signed [VEC_W-1:0]  vy;
		logic signed [VEC_W-1:0]  vz;
	} pay_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [CZ-1:0] z;
		logic                 neg;
	} cord_t;

	function automatic logic signed [CZ-1:0] atan_q30(input int i);
		case (i)
			0:  return CZ'(64'sd843314857);
			1:  return CZ'(64'sd497837829);
			2:  return CZ'(64'sd263043837);
			3:  return CZ'(64'sd133525159);
			4:  return CZ'(64'sd67021687);
			5:  return CZ'(64'sd33543516);
			6:  return CZ'(64'sd16775851);
			7:  return CZ'(64'sd8388437);
			8:  return CZ'(64'sd4194283);
			9:  return CZ'(64'sd2097149);
			10: return CZ'(64'sd1048576);
			11: return CZ'(64'sd524288);
			12: return CZ'(64'sd262144);
			13: return CZ'(64'sd131072);
			14: return CZ'(64'sd65536);
			15: return CZ'(64'sd32768);
			16: return CZ'(64'sd16384);
			17: return CZ'(64'sd8192);
			18: return CZ'(64'sd4096);
			19: return CZ'(64'sd2048);
			20: return CZ'(64'sd1024);
			21: return CZ'(64'sd512);
			22: return CZ'(64'sd256);
			23: return CZ'(64'sd128);
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== sv/rotate_vector_about_axis_core.sv =====
`default_nettype none
// Channel | handshake           | payload
// --------+---------------------+----------------------------------------------
// in      | in_valid, in_ready  | axis_x/y/z, angle, vec_x/y/z
// out     | out_valid, out_ready| rot_x/y/z, overflow
//
// One transaction per cycle sustained while out_ready is high; the pipeline
// holds one register per CORDIC iteration plus angle reduction, matrix build,
// products and final sum.
// Every stage holds its own valid bit and advances when empty or when the
// stage after it advances, so bubbles close up under an output stall.
// arst_n clears all valid bits; the datapath registers carry no reset.
module rotate_vector_about_axis_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire logic signed [rva_pkg::AXIS_W-1:0]  axis_x,
	input  wire logic signed [rva_pkg::AXIS_W-1:0]  axis_y,
	input  wire logic signed [rva_pkg::AXIS_W-1:0]  axis_z,
	input  wire logic signed [rva_pkg::ANGLE_W-1:0] angle,
	input  wire logic signed [rva_pkg::VEC_W-1:0]   vec_x,
	input  wire logic signed [rva_pkg::VEC_W-1:0]   vec_y,
	input  wire logic signed [rva_pkg::VEC_W-1:0]   vec_z,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [rva_pkg::VEC_W-1:0]        rot_x,
	output logic signed [rva_pkg::VEC_W-1:0]        rot_y,
	output logic signed [rva_pkg::VEC_W-1:0]        rot_z,
	output logic                                overflow
);
	import rva_pkg::*;

	localparam int ST_FOLD = RED_STEPS + 1;
	localparam int ST_HALF = RED_STEPS + 2;
	localparam int ST_CEND = ST_HALF + CORDIC_STEPS;
	localparam int ST_T    = ST_CEND + 1;
	localparam int ST_P1   = ST_CEND + 2;
	localparam int ST_P2   = ST_CEND + 3;
	localparam int ST_P3   = ST_CEND + 4;
	localparam int NS      = ST_CEND + 5;

	localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(Q30_TWO_PI);
	localparam logic signed [ZW-1:0] PI_Z      = ZW'(Q30_PI);
	localparam logic signed [CZ-1:0] PI_C      = CZ'(Q30_PI);
	localparam logic signed [CZ-1:0] HALF_PI_C = CZ'(Q30_HALF_PI);
	localparam logic signed [MW-1:0] COEF_HI   = MW'((64'sd1 <<< (COEF_W - 1)) - 64'sd1);
	localparam logic signed [MW-1:0] COEF_LO   = -MW'(64'sd1 <<< (COEF_W - 1));
	localparam logic signed [RW-1:0] ROT_HI    = RW'((64'sd1 <<< (VEC_W - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] ROT_LO    = -RW'(64'sd1 <<< (VEC_W - 1));
	localparam logic signed [SW-1:0] ROUND_C   = SW'(64'sd1 <<< (MAT_FRAC - 1));

	// stage handshake
	logic [NS:1]   v_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = v_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// axis and vector ride along to the product stage
	pay_t pay_in;
	pay_t pay_s [1:ST_P2];

	assign pay_in = '{ax: axis_x, ay: axis_y, az: axis_z, vx: vec_x, vy: vec_y, vz: vec_z};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pay_s[1] <= pay_in;
		end
		for (int k = 2; k <= ST_P2; k++) begin
			if (en[k]) begin
				pay_s[k] <= pay_s[k-1];
			end
		end
	end

	// truncating modulo 2*pi by binary restoring steps, sign kept
	logic signed [ZW-1:0] z0;
	logic signed [ZW-1:0] rz_d [1:RED_STEPS];
	logic signed [ZW-1:0] rz_s [1:RED_STEPS];

	assign z0 = ZW'(angle) <<< ANG_SHIFT;

	always_comb begin
		logic signed [ZW-1:0] zin;
		logic signed [ZW-1:0] md;
		for (int k = 1; k <= RED_STEPS; k++) begin
			zin = (k == 1) ? z0 : rz_s[(k > 1) ? k - 1 : 1];
			md  = TWO_PI_Z <<< (RED_STEPS - k);
			if (!zin[ZW-1] && zin >= md) begin
				rz_d[k] = zin - md;
			end else if (zin[ZW-1] && zin <= -md) begin
				rz_d[k] = zin + md;
			end else begin
				rz_d[k] = zin;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= RED_STEPS; k++) begin
			if (en[k]) begin
				rz_s[k] <= rz_d[k];
			end
		end
	end

	// fold into [-pi, pi], then into [-pi/2, pi/2]
	logic signed [ZW-1:0] fz_d;
	logic signed [CZ-1:0] fz_s;
	cord_t                half_d;

	always_comb begin
		if (rz_s[RED_STEPS] > PI_Z) begin
			fz_d = rz_s[RED_STEPS] - TWO_PI_Z;
		end else if (rz_s[RED_STEPS] < -PI_Z) begin
			fz_d = rz_s[RED_STEPS] + TWO_PI_Z;
		end else begin
			fz_d = rz_s[RED_STEPS];
		end
	end

	always_comb begin
		half_d.x   = XW'(Q30_GAIN);
		half_d.y   = '0;
		half_d.neg = 1'b0;
		half_d.z   = fz_s;
		if (fz_s > HALF_PI_C) begin
			half_d.z   = fz_s - PI_C;
			half_d.neg = 1'b1;
		end else if (fz_s < -HALF_PI_C) begin
			half_d.z   = fz_s + PI_C;
			half_d.neg = 1'b1;
		end
	end

	// one CORDIC iteration per stage
	cord_t cs_s [ST_HALF:ST_CEND];
	cord_t cs_d [ST_HALF+1:ST_CEND];

	always_comb begin
		int    i;
		cord_t c;
		for (int k = ST_HALF + 1; k <= ST_CEND; k++) begin
			i = k - ST_HALF - 1;
			c = cs_s[k-1];
			cs_d[k].neg = c.neg;
			if (!c.z[CZ-1]) begin
				cs_d[k].x = c.x - (c.y >>> i);
				cs_d[k].y = c.y + (c.x >>> i);
				cs_d[k].z = c.z - atan_q30(i);
			end else begin
				cs_d[k].x = c.x + (c.y >>> i);
				cs_d[k].y = c.y - (c.x >>> i);
				cs_d[k].z = c.z + atan_q30(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_FOLD]) begin
			fz_s <= CZ'(fz_d);
		end
		if (en[ST_HALF]) begin
			cs_s[ST_HALF] <= half_d;
		end
		for (int k = ST_HALF + 1; k <= ST_CEND; k++) begin
			if (en[k]) begin
				cs_s[k] <= cs_d[k];
			end
		end
	end

	// tail: trig fixup and axis products, matrix terms, coefficients,
	// coefficient-by-vector products, row sums
	logic signed [XW-1:0]  c_s1, s_s1;
	logic signed [CFW-1:0] cf_s1;
	logic signed [AAW-1:0] aa_s1 [6];
	logic signed [QW-1:0]  q_s2 [6];
	logic signed [QW-1:0]  w_s2 [3];
	logic signed [QW-1:0]  c_s2;
	logic signed [COEF_W-1:0] m_s3 [9];
	logic                  ovf_s3;
	logic signed [PW-1:0]  p_s4 [9];
	logic                  ovf_s4;
	logic signed [VEC_W-1:0] rot_s5 [3];
	logic                  ovf_s5;

	logic signed [XW-1:0]     c_d;
	logic signed [AXIS_W-1:0] a_t [3];
	logic signed [AXIS_W-1:0] a_p [3];
	logic signed [VEC_W-1:0]  v_p [3];
	logic signed [COEF_W-1:0] m_d [9];
	logic                     ovf_m;
	logic signed [VEC_W-1:0]  rot_d [3];
	logic                     ovf_r;

	assign c_d    = cs_s[ST_CEND].neg ? -cs_s[ST_CEND].x : cs_s[ST_CEND].x;
	assign a_t[0] = pay_s[ST_CEND].ax;
	assign a_t[1] = pay_s[ST_CEND].ay;
	assign a_t[2] = pay_s[ST_CEND].az;
	assign a_p[0] = pay_s[ST_T].ax;
	assign a_p[1] = pay_s[ST_T].ay;
	assign a_p[2] = pay_s[ST_T].az;
	assign v_p[0] = pay_s[ST_P2].vx;
	assign v_p[1] = pay_s[ST_P2].vy;
	assign v_p[2] = pay_s[ST_P2].vz;

	always_ff @(posedge clk) begin
		if (en[ST_T]) begin
			c_s1     <= c_d;
			s_s1     <= cs_s[ST_CEND].neg ? -cs_s[ST_CEND].y : cs_s[ST_CEND].y;
			cf_s1    <= CFW'(Q30_ONE) - CFW'(c_d);
			aa_s1[0] <= AAW'((36'(a_t[0]) * 36'(a_t[0])) >>> FRAC_BITS);
			aa_s1[1] <= AAW'((36'(a_t[0]) * 36'(a_t[1])) >>> FRAC_BITS);
			aa_s1[2] <= AAW'((36'(a_t[0]) * 36'(a_t[2])) >>> FRAC_BITS);
			aa_s1[3] <= AAW'((36'(a_t[1]) * 36'(a_t[1])) >>> FRAC_BITS);
			aa_s1[4] <= AAW'((36'(a_t[1]) * 36'(a_t[2])) >>> FRAC_BITS);
			aa_s1[5] <= AAW'((36'(a_t[2]) * 36'(a_t[2])) >>> FRAC_BITS);
		end
		if (en[ST_P1]) begin
			for (int j = 0; j < 6; j++) begin
				q_s2[j] <= QW'(((AAW + CFW)'(aa_s1[j]) * (AAW + CFW)'(cf_s1)) >>> FRAC_BITS);
			end
			for (int j = 0; j < 3; j++) begin
				w_s2[j] <= QW'(((AXIS_W + XW)'(a_p[j]) * (AXIS_W + XW)'(s_s1)) >>> FRAC_BITS);
			end
			c_s2 <= QW'(c_s1);
		end
		if (en[ST_P2]) begin
			m_s3   <= m_d;
			ovf_s3 <= ovf_m;
		end
		if (en[ST_P3]) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					p_s4[3*r+j] <= PW'(m_s3[3*r+j]) * PW'(v_p[j]);
				end
			end
			ovf_s4 <= ovf_s3;
		end
		if (en[NS]) begin
			rot_s5 <= rot_d;
			ovf_s5 <= ovf_r;
		end
	end

	// Rodrigues matrix, then floor to Q26 and saturate each coefficient
	always_comb begin
		logic signed [MW-1:0] raw [9];
		logic signed [MW-1:0] sh;
		raw[0] = MW'(q_s2[0]) + MW'(c_s2);
		raw[1] = MW'(q_s2[1]) - MW'(w_s2[2]);
		raw[2] = MW'(q_s2[2]) + MW'(w_s2[1]);
		raw[3] = MW'(q_s2[1]) + MW'(w_s2[2]);
		raw[4] = MW'(q_s2[3]) + MW'(c_s2);
		raw[5] = MW'(q_s2[4]) - MW'(w_s2[0]);
		raw[6] = MW'(q_s2[2]) - MW'(w_s2[1]);
		raw[7] = MW'(q_s2[4]) + MW'(w_s2[0]);
		raw[8] = MW'(q_s2[5]) + MW'(c_s2);
		ovf_m  = 1'b0;
		for (int j = 0; j < 9; j++) begin
			sh = raw[j] >>> (TRIG_FRAC - MAT_FRAC);
			if (sh > COEF_HI) begin
				m_d[j] = COEF_W'(COEF_HI);
				ovf_m  = 1'b1;
			end else if (sh < COEF_LO) begin
				m_d[j] = COEF_W'(COEF_LO);
				ovf_m  = 1'b1;
			end else begin
				m_d[j] = COEF_W'(sh);
			end
		end
	end

	// row sums, round half up, saturate
	always_comb begin
		logic signed [SW-1:0] sum;
		logic signed [RW-1:0] rs;
		ovf_r = ovf_s4;
		for (int r = 0; r < 3; r++) begin
			sum = SW'(p_s4[3*r]) + SW'(p_s4[3*r+1]) + SW'(p_s4[3*r+2]) + ROUND_C;
			rs  = RW'(sum >>> MAT_FRAC);
			if (rs > ROT_HI) begin
				rot_d[r] = VEC_W'(ROT_HI);
				ovf_r    = 1'b1;
			end else if (rs < ROT_LO) begin
				rot_d[r] = VEC_W'(ROT_LO);
				ovf_r    = 1'b1;
			end else begin
				rot_d[r] = VEC_W'(rs);
			end
		end
	end

	assign rot_x    = rot_s5[0];
	assign rot_y    = rot_s5[1];
	assign rot_z    = rot_s5[2];
	assign overflow = ovf_s5;

	// transactions in flight change only by what enters and what leaves
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1 |=> (!$past(arst_n) || $countones(v_q) == $past($countones(v_q))
			+ int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))))
		else $error("pipeline occupancy mismatch");

	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_FOLD] |-> (fz_s <= PI_C && fz_s >= -PI_C))
		else $error("angle not folded into [-pi, pi]");

	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_HALF] |-> (cs_s[ST_HALF].z <= HALF_PI_C && cs_s[ST_HALF].z >= -HALF_PI_C))
		else $error("CORDIC start angle outside [-pi/2, pi/2]");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&v_q && !out_ready) |-> !in_ready)
		else $error("input taken while every stage is held");

endmodule
`default_nettype wire

// ===== sim/rotate_vector_about_axis_core_tb.sv =====
module rotate_vector_about_axis_core_tb;
	import rva_pkg::*;

	typedef struct {
		logic signed [AXIS_W-1:0]  ax, ay, az;
		logic signed [ANGLE_W-1:0] ang;
		logic signed [VEC_W-1:0]   vx, vy, vz;
	} rot_req_t;

	typedef struct {
		logic signed [VEC_W-1:0] rx, ry, rz;
		logic                    ovf;
	} rot_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [AXIS_W-1:0]  axis_x = '0, axis_y = '0, axis_z = '0;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic signed [VEC_W-1:0]   vec_x = '0, vec_y = '0, vec_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VEC_W-1:0] rot_x, rot_y, rot_z;
	logic overflow;

	rot_res_t rotated_q[$];
	int errors = 0;
	int max_gap = 12;
	int hold_cycles = 0;

	rotate_vector_about_axis_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic rot_res_t rotate_predict(rot_req_t r);
		longint z, x, y, nx, c, s, cf;
		longint a[3], q[3][3], w[3], m[3][3];
		logic signed [127:0] acc;
		logic signed [127:0] v[3];
		logic signed [63:0] lim;
		logic ovf;
		logic sel_neg;
		rot_res_t res;
		ovf = 1'b0;
		sel_neg = 1'b0;
		a[0] = longint'(r.ax); a[1] = longint'(r.ay); a[2] = longint'(r.az);
		v[0] = 128'(r.vx); v[1] = 128'(r.vy); v[2] = 128'(r.vz);
		z = (longint'(r.ang) * (longint'(1) << (TRIG_FRAC - FRAC_BITS))) % Q30_TWO_PI;
		if (z > Q30_PI) z -= Q30_TWO_PI;
		if (z < -Q30_PI) z += Q30_TWO_PI;
		if (z > Q30_HALF_PI) begin
			z -= Q30_PI; sel_neg = 1'b1;
		end else if (z < -Q30_HALF_PI) begin
			z += Q30_PI; sel_neg = 1'b1;
		end
		x = Q30_GAIN; y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i); y = y + fshr(x, i); z -= atan_q30(i);
			end else begin
				nx = x + fshr(y, i); y = y - fshr(x, i); z += atan_q30(i);
			end
			x = nx;
		end
		c = sel_neg ? -x : x;
		s = sel_neg ? -y : y;
		cf = Q30_ONE - c;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				q[i][j] = fshr(fshr(a[i] * a[j], FRAC_BITS) * cf, FRAC_BITS);
			w[i] = fshr(a[i] * s, FRAC_BITS);
		end
		m[0][0] = q[0][0] + c;    m[0][1] = q[0][1] - w[2]; m[0][2] = q[0][2] + w[1];
		m[1][0] = q[0][1] + w[2]; m[1][1] = q[1][1] + c;    m[1][2] = q[1][2] - w[0];
		m[2][0] = q[0][2] - w[1]; m[2][1] = q[1][2] + w[0]; m[2][2] = q[2][2] + c;
		lim = 64'sd1 <<< 30;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				m[i][j] = fshr(m[i][j], TRIG_FRAC - MAT_FRAC);
				if (m[i][j] < -lim) begin m[i][j] = -lim; ovf = 1'b1; end
				if (m[i][j] > lim - 1) begin m[i][j] = lim - 1; ovf = 1'b1; end
			end
		for (int i = 0; i < 3; i++) begin
			acc = 128'(m[i][0]) * v[0] + 128'(m[i][1]) * v[1] + 128'(m[i][2]) * v[2];
			acc = (acc + (128'sd1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
			if (acc < -128'sd2147483648) begin acc = -128'sd2147483648; ovf = 1'b1; end
			if (acc > 128'sd2147483647) begin acc = 128'sd2147483647; ovf = 1'b1; end
			case (i)
				0: res.rx = acc[31:0];
				1: res.ry = acc[31:0];
				default: res.rz = acc[31:0];
			endcase
		end
		res.ovf = ovf;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// sender: present one transaction and return once it is taken
	task automatic send_rotation(rot_req_t r);
		int gap;
		gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		axis_x <= r.ax; axis_y <= r.ay; axis_z <= r.az;
		angle <= r.ang;
		vec_x <= r.vx; vec_y <= r.vy; vec_z <= r.vz;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		rotated_q.push_back(rotate_predict(r));
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
		end
	end

	// checker: sample mid-cycle, transaction lands on the next rising edge
	always @(negedge clk) begin
		rot_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				report_mismatch("result transactions pending", 1, 0);
			end else begin
				e = rotated_q.pop_front();
				if (rot_x !== e.rx) report_mismatch("rot_x", rot_x, e.rx);
				if (rot_y !== e.ry) report_mismatch("rot_y", rot_y, e.ry);
				if (rot_z !== e.rz) report_mismatch("rot_z", rot_z, e.rz);
				if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
			end
		end
	end

	function automatic rot_req_t make_req(int ax, int ay, int az, int ang,
			int vx, int vy, int vz);
		rot_req_t r;
		r.ax = AXIS_W'(ax); r.ay = AXIS_W'(ay); r.az = AXIS_W'(az);
		r.ang = ANGLE_W'(ang);
		r.vx = vx; r.vy = vy; r.vz = vz;
		return r;
	endfunction

	function automatic rot_req_t random_req();
		rot_req_t r;
		real ux, uy, uz, n;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			// unit axis, angle within two pi
			ux = $itor($signed($urandom_range(0, 2000)) - 1000);
			uy = $itor($signed($urandom_range(0, 2000)) - 1000);
			uz = $itor($signed($urandom_range(0, 2000)) - 1000);
			n = $sqrt(ux * ux + uy * uy + uz * uz);
			if (n < 1.0) begin ux = 1.0; n = 1.0; end
			r.ax = AXIS_W'($rtoi(ux / n * 65536.0));
			r.ay = AXIS_W'($rtoi(uy / n * 65536.0));
			r.az = AXIS_W'($rtoi(uz / n * 65536.0));
			r.ang = ANGLE_W'($signed($urandom_range(0, 823550)) - 411775);
		end else begin
			r.ax = AXIS_W'($urandom); r.ay = AXIS_W'($urandom); r.az = AXIS_W'($urandom);
			r.ang = ANGLE_W'($urandom);
		end
		if ($urandom_range(0, 3) == 0) begin
			r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
		end else begin
			r.vx = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
			r.vy = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
			r.vz = $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
		end
		return r;
	endfunction

	task automatic wait_drained();
		while (rotated_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_rotation(make_req(65536, 0, 0, 0, 65536, 65536, 65536));
		send_rotation(make_req(0, 0, 65536, 102944, 65536, 0, 0));
		send_rotation(make_req(0, 65536, 0, -102944, 0, 0, 65536));
		send_rotation(make_req(0, 0, 65536, 205887, 65536, 131072, 0));
		send_rotation(make_req(0, 0, 65536, -205887, 65536, 131072, 0));
		send_rotation(make_req(65536, 0, 0, 411775, 1, 2, 3));
		send_rotation(make_req(65536, 0, 0, -411775, 1, 2, 3));
		send_rotation(make_req(0, 65536, 0, 308831, 100000, -7, 42));
		// angle beyond two pi, field extremes
		send_rotation(make_req(0, 0, 65536, 524287, 65536, 0, 0));
		send_rotation(make_req(0, 0, 65536, -524288, 65536, 0, 0));
		send_rotation(make_req(131071, 131071, 131071, 205887,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_rotation(make_req(-131072, -131072, -131072, 102944,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_rotation(make_req(-131072, 131071, -131072, -524288,
			32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_rotation(make_req(0, 0, 0, 51472, 32'h7fffffff, -5, 5));
		send_rotation(make_req(37837, 37837, 37837, 137259, 32'h40000000, 0, -65536));
		send_rotation(make_req(65536, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0));
		send_rotation(make_req(-65536, 0, 0, 1, 0, 0, 0));
		send_rotation(make_req(0, -65536, 0, -1, -1, -1, -1));
		go_idle();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			// stretches without idle cycles on either side
			if (i % 150 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 12;
			send_rotation(random_req());
		end
		go_idle();
		max_gap = 12;
	endtask

	task automatic test_backpressure();
		max_gap = 0;
		hold_cycles = 300;
		for (int i = 0; i < 80; i++) send_rotation(random_req());
		go_idle();
		max_gap = 12;
	endtask

	task automatic test_pause_drain();
		for (int i = 0; i < 20; i++) send_rotation(random_req());
		go_idle();
		wait_drained();
		for (int i = 0; i < 20; i++) send_rotation(random_req());
		go_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_backpressure();
		test_pause_drain();
		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0 && rotated_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== rotate_vector_about_axis_core.f =====
sv/rva_pkg.sv
sv/rotate_vector_about_axis_core.sv
sim/rotate_vector_about_axis_core_tb.sv
